// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ordered keyed table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OKT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("okt assertion failed");
`define OKT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("okt implication failed");
`define OKT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("okt next-cycle check failed");
`else
`define OKT_ASSERT(lbl, clk, rstn, prop)
`define OKT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OKT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/okt_pkg.sv =====
// Types, constants and helpers of the ordered keyed table.
package okt_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W        = CNT_W + 1;

    typedef enum logic [2:0] {
        OP_UPSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_PUBLISH = 3'd3,
        OP_BEGIN   = 3'd4,
        OP_END     = 3'd5,
        OP_READ    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_KEY_ZERO  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        TC_NOP,
        TC_CLEAR,
        TC_READ,
        TC_UPSERT,
        TC_REMOVE
    } tbl_op_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_MATCH,
        TS_MISS,
        TS_SHIFT,
        TS_READ_WAIT,
        TS_REPLY
    } tbl_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_RUN
    } top_state_t;

    typedef struct packed {
        logic [63:0]             key;
        logic [15:0]             stacks;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [31:0]             seq;
    } entry_t;

    typedef struct packed {
        tbl_op_t                 op;
        logic [63:0]             key;
        logic [15:0]             stacks;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [3:0]              index;
    } tbl_cmd_t;

    typedef struct packed {
        status_t      status;
        logic [63:0]  entry_key;
        logic [15:0]  entry_stacks;
        logic [31:0]  entry_payload;
        logic [31:0]  entry_sequence;
        logic [CNT_W-1:0] count;
        logic         changed;
    } tbl_rsp_t;

    typedef struct packed {
        status_t      status;
        logic [63:0]  entry_key;
        logic [15:0]  entry_stacks;
        logic [31:0]  entry_payload;
        logic [31:0]  entry_sequence;
        logic [4:0]   live_count;
        logic [31:0]  revision_out;
        logic [63:0]  generation_out;
        logic [31:0]  frame_out;
        logic         frame_valid;
    } okt_out_t;

    function automatic logic [PAYLOAD_BITS-1:0] pay_from_in(input logic [31:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[PAYLOAD_BITS-1:0];
    endfunction

    function automatic logic [31:0] pay_to_out(input logic [PAYLOAD_BITS-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

endpackage

// ===== rtl/okt_if.sv =====
// Request and result channel interfaces of the ordered keyed table.
interface okt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] key;
    logic [15:0] stacks;
    logic [31:0] payload;
    logic [63:0] generation;
    logic [31:0] frame;
    logic [3:0]  index;

    modport source (output valid, op, key, stacks, payload, generation, frame, index,
                    input ready);
    modport sink   (input valid, op, key, stacks, payload, generation, frame, index,
                    output ready);
endinterface

interface okt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] entry_key;
    logic [15:0] entry_stacks;
    logic [31:0] entry_payload;
    logic [31:0] entry_sequence;
    logic [4:0]  live_count;
    logic [31:0] revision_out;
    logic [63:0] generation_out;
    logic [31:0] frame_out;
    logic        frame_valid;

    modport source (output valid, status, entry_key, entry_stacks, entry_payload,
                    entry_sequence, live_count, revision_out, generation_out,
                    frame_out, frame_valid,
                    input ready);
    modport sink   (input valid, status, entry_key, entry_stacks, entry_payload,
                    entry_sequence, live_count, revision_out, generation_out,
                    frame_out, frame_valid,
                    output ready);
endinterface

// ===== rtl/ordered_keyed_table_engine_top.sv =====
// Top level of the ordered keyed table engine: session state, revision and channels.
// Path of an op through the table: clear, session, unused ops and zero keys reply
//   straight from idle; a read waits on one memory read; upsert or remove that misses
//   scans one entry per cycle, then takes a final step; a remove that hits scans
//   to the hit, then moves one entry per cycle.
// Throughput: one op at a time; a new request is taken once the prior result is registered.
// Reset (rst_n, async, active low) clears count, sequence, revision and session state;
//   stored entries are not swept, the zero count hides them.
`include "assert_macros.svh"

module ordered_keyed_table_engine_top (
    input  logic clk,
    input  logic rst_n,
    okt_req_if.sink   req,
    okt_rsp_if.source rsp
);
    import okt_pkg::*;

    top_state_t   state_reg, state_next;
    logic [63:0]  gen_reg, gen_next;
    logic [31:0]  frame_reg, frame_next;
    logic         has_frame_reg, has_frame_next;
    logic [31:0]  rev_reg, rev_next;
    status_t      sess_status_reg, sess_status_next;
    okt_out_t     out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    logic         tbl_start;
    logic         tbl_ack;
    logic         tbl_done;
    tbl_cmd_t     tbl_cmd;
    tbl_rsp_t     tbl_rsp;
    logic         slot_free;

    // Entry store and its scan / compaction sequencer
    okt_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tbl_start),
        .cmd   (tbl_cmd),
        .ack   (tbl_ack),
        .done  (tbl_done),
        .rsp   (tbl_rsp)
    );

    // The output register frees up in the same cycle its result transfers
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == TOP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= TOP_IDLE;
            gen_reg         <= '0;
            frame_reg       <= '0;
            has_frame_reg   <= 1'b0;
            rev_reg         <= '0;
            sess_status_reg <= ST_DONE;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gen_reg         <= gen_next;
            frame_reg       <= frame_next;
            has_frame_reg   <= has_frame_next;
            rev_reg         <= rev_next;
            sess_status_reg <= sess_status_next;
            out_reg         <= out_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        gen_next         = gen_reg;
        frame_next       = frame_reg;
        has_frame_next   = has_frame_reg;
        rev_next         = rev_reg;
        sess_status_next = sess_status_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        tbl_start        = 1'b0;
        tbl_ack          = 1'b0;
        tbl_cmd.op       = TC_NOP;
        tbl_cmd.key      = req.key;
        tbl_cmd.stacks   = (req.stacks == 16'd0) ? 16'd1 : req.stacks;
        tbl_cmd.payload  = pay_from_in(req.payload);
        tbl_cmd.index    = req.index;

        unique case (state_reg)
            TOP_IDLE:
            begin
                if (req.valid)
                begin
                    // Session fields settle at the request transfer; any table
                    // wipe or revision bump rides on the table op issued here
                    tbl_start        = 1'b1;
                    state_next       = TOP_RUN;
                    sess_status_next = ST_DONE;
                    unique case (op_t'(req.op))
                        OP_UPSERT: tbl_cmd.op = TC_UPSERT;
                        OP_REMOVE: tbl_cmd.op = TC_REMOVE;
                        OP_CLEAR:  tbl_cmd.op = TC_CLEAR;
                        OP_READ:   tbl_cmd.op = TC_READ;
                        OP_PUBLISH:
                        begin
                            if (req.generation == 64'd0)
                            begin
                                sess_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                if (req.generation != gen_reg)
                                begin
                                    tbl_cmd.op = TC_CLEAR;
                                    gen_next   = req.generation;
                                end
                                frame_next     = req.frame;
                                has_frame_next = 1'b1;
                            end
                        end
                        OP_BEGIN:
                        begin
                            tbl_cmd.op     = TC_CLEAR;
                            frame_next     = '0;
                            has_frame_next = 1'b0;
                            gen_next       = req.generation;
                        end
                        OP_END:
                        begin
                            if (req.generation != 64'd0 && req.generation != gen_reg)
                            begin
                                sess_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                tbl_cmd.op     = TC_CLEAR;
                                frame_next     = '0;
                                has_frame_next = 1'b0;
                                gen_next       = '0;
                            end
                        end
                        default:
                        begin
                            tbl_cmd.op = TC_NOP;
                        end
                    endcase
                end
            end

            TOP_RUN:
            begin
                if (tbl_done && slot_free)
                begin
                    // Release the table and load the result register
                    tbl_ack                 = 1'b1;
                    rev_next                = rev_reg + 32'(tbl_rsp.changed);
                    out_next.status         = (sess_status_reg == ST_DONE) ? tbl_rsp.status
                                                                            : sess_status_reg;
                    out_next.entry_key      = tbl_rsp.entry_key;
                    out_next.entry_stacks   = tbl_rsp.entry_stacks;
                    out_next.entry_payload  = tbl_rsp.entry_payload;
                    out_next.entry_sequence = tbl_rsp.entry_sequence;
                    out_next.live_count     = 5'(tbl_rsp.count);
                    out_next.revision_out   = rev_next;
                    out_next.generation_out = gen_reg;
                    out_next.frame_out      = frame_reg;
                    out_next.frame_valid    = has_frame_reg;
                    out_valid_next          = 1'b1;
                    state_next              = TOP_IDLE;
                end
            end

            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.entry_key      = out_reg.entry_key;
    assign rsp.entry_stacks   = out_reg.entry_stacks;
    assign rsp.entry_payload  = out_reg.entry_payload;
    assign rsp.entry_sequence = out_reg.entry_sequence;
    assign rsp.live_count     = out_reg.live_count;
    assign rsp.revision_out   = out_reg.revision_out;
    assign rsp.generation_out = out_reg.generation_out;
    assign rsp.frame_out      = out_reg.frame_out;
    assign rsp.frame_valid    = out_reg.frame_valid;

    `OKT_ASSERT_IMP(a_frame_needs_gen, clk, rst_n, has_frame_reg, gen_reg != 64'd0)
    `OKT_ASSERT_IMP(a_done_in_run, clk, rst_n, tbl_done, state_reg == TOP_RUN)
    `OKT_ASSERT_NXT(a_ack_loads_out, clk, rst_n, tbl_ack,
                    out_valid_reg && state_reg == TOP_IDLE)

endmodule

// ===== rtl/okt_table.sv =====
// Entry store with a one-entry-per-cycle key scan and compaction sequencer.
`include "assert_macros.svh"

module okt_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  okt_pkg::tbl_cmd_t cmd,
    input  logic             ack,
    output logic             done,
    output okt_pkg::tbl_rsp_t rsp
);
    import okt_pkg::*;

    tbl_state_t        state_reg, state_next;
    tbl_cmd_t          cmd_reg, cmd_next;
    tbl_rsp_t          rsp_reg, rsp_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       seq_reg, seq_next;

    entry_t            mem [TABLE_DEPTH];
    entry_t            rd_data_reg;
    entry_t            wr_data;
    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;

    logic [SUM_W-1:0]  ptr_p1, ptr_p2, cnt_ext;
    logic              reply;

    assign ptr_p1  = SUM_W'(ptr_reg) + SUM_W'(1);
    assign ptr_p2  = SUM_W'(ptr_reg) + SUM_W'(2);
    assign cnt_ext = SUM_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
            cmd_reg   <= '0;
            rsp_reg   <= '0;
            ptr_reg   <= '0;
            count_reg <= '0;
            seq_reg   <= 32'd1;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            rsp_reg   <= rsp_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rsp_next   = rsp_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data_reg;
        reply      = 1'b0;

        unique case (state_reg)
            TS_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    ptr_next = '0;
                    rsp_next = '0;
                    unique case (cmd.op)
                        TC_CLEAR:
                        begin
                            count_next       = '0;
                            rsp_next.changed = 1'b1;
                            reply            = 1'b1;
                        end
                        TC_READ:
                        begin
                            if (32'(cmd.index) < 32'(count_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(cmd.index);
                                state_next = TS_READ_WAIT;
                            end
                            else
                            begin
                                reply = 1'b1;
                            end
                        end
                        TC_UPSERT, TC_REMOVE:
                        begin
                            if (cmd.key == 64'd0)
                            begin
                                rsp_next.status = ST_KEY_ZERO;
                                reply           = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = TS_MISS;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = TS_MATCH;
                            end
                        end
                        default:
                        begin
                            reply = 1'b1;
                        end
                    endcase
                end
            end

            TS_MATCH:
            begin
                if (rd_data_reg.key == cmd_reg.key)
                begin
                    if (cmd_reg.op == TC_UPSERT)
                    begin
                        // Hit: overwrite in place, keep the sequence number
                        wr_en            = 1'b1;
                        wr_data.key      = cmd_reg.key;
                        wr_data.stacks   = cmd_reg.stacks;
                        wr_data.payload  = cmd_reg.payload;
                        wr_data.seq      = rd_data_reg.seq;
                        rsp_next.changed = 1'b1;
                        reply            = 1'b1;
                    end
                    else if (ptr_p1 < cnt_ext)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(ptr_p1);
                        state_next = TS_SHIFT;
                    end
                    else
                    begin
                        count_next       = count_reg - CNT_W'(1);
                        rsp_next.changed = 1'b1;
                        reply            = 1'b1;
                    end
                end
                else if (ptr_p1 < cnt_ext)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IDX_W'(ptr_p1);
                    ptr_next = IDX_W'(ptr_p1);
                end
                else
                begin
                    state_next = TS_MISS;
                end
            end

            TS_MISS:
            begin
                if (cmd_reg.op == TC_REMOVE)
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
                else if (32'(count_reg) >= TABLE_DEPTH)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    // Append at the tail with the next nonzero sequence
                    wr_en            = 1'b1;
                    wr_addr          = IDX_W'(count_reg);
                    wr_data.key      = cmd_reg.key;
                    wr_data.stacks   = cmd_reg.stacks;
                    wr_data.payload  = cmd_reg.payload;
                    wr_data.seq      = seq_reg;
                    seq_next         = (seq_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                  : seq_reg + 32'd1;
                    count_next       = count_reg + CNT_W'(1);
                    rsp_next.changed = 1'b1;
                end
                reply = 1'b1;
            end

            TS_SHIFT:
            begin
                // Move entry ptr+1 down to ptr, fetch the one after it
                wr_en = 1'b1;
                if (ptr_p2 < cnt_ext)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IDX_W'(ptr_p2);
                    ptr_next = IDX_W'(ptr_p1);
                end
                else
                begin
                    count_next       = count_reg - CNT_W'(1);
                    rsp_next.changed = 1'b1;
                    reply            = 1'b1;
                end
            end

            TS_READ_WAIT:
            begin
                rsp_next.entry_key      = rd_data_reg.key;
                rsp_next.entry_stacks   = rd_data_reg.stacks;
                rsp_next.entry_payload  = pay_to_out(rd_data_reg.payload);
                rsp_next.entry_sequence = rd_data_reg.seq;
                reply                   = 1'b1;
            end

            TS_REPLY:
            begin
                if (ack)
                begin
                    state_next = TS_IDLE;
                end
            end

            default:
            begin
                state_next = TS_IDLE;
            end
        endcase

        if (reply)
        begin
            rsp_next.count = count_next;
            state_next     = TS_REPLY;
        end
    end

    assign done = (state_reg == TS_REPLY);
    assign rsp  = rsp_reg;

    `OKT_ASSERT(a_count_bound, clk, rst_n, 32'(count_reg) <= TABLE_DEPTH)
    `OKT_ASSERT_IMP(a_start_idle, clk, rst_n, start, state_reg == TS_IDLE)
    `OKT_ASSERT_NXT(a_reply_hold, clk, rst_n, done && !ack,
                    done && $stable(rsp_reg) && $stable(count_reg))

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the ordered keyed table engine: directed cases, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import okt_pkg::*;

    localparam int         CLK_HALF      = 6;
    localparam logic [2:0] OP_UNUSED     = 3'd7;
    localparam int         KEY_POOL_SIZE = 24;
    localparam int         GEN_POOL_SIZE = 4;
    // Worst op is a full scan that misses.
    localparam int         DRAIN_CYCLES  = 2 * TABLE_DEPTH + 8;
    localparam int         CYCLE_LIMIT   = 600000;

    // One request as the sender sees it.
    typedef struct {
        logic [2:0]  op;
        logic [63:0] key;
        logic [15:0] stacks;
        logic [31:0] payload;
        logic [63:0] generation;
        logic [31:0] frame;
        logic [3:0]  index;
    } table_req_t;

    logic clk;
    logic rst_n;

    okt_req_if req_ch ();
    okt_rsp_if rsp_ch ();

    ordered_keyed_table_engine_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table and the session state.
    logic [63:0] shadow_key     [TABLE_DEPTH];
    logic [15:0] shadow_stacks  [TABLE_DEPTH];
    logic [31:0] shadow_payload [TABLE_DEPTH];
    logic [31:0] shadow_seq     [TABLE_DEPTH];
    int          live_entries;
    logic [31:0] seq_next;
    logic [31:0] rev_count;
    logic [63:0] cur_generation;
    logic [31:0] cur_frame;
    logic        frame_seen;

    // Results still owed by the block, oldest first.
    okt_out_t    pending_results [$];

    logic [63:0] key_pool [KEY_POOL_SIZE];
    logic [63:0] gen_pool [GEN_POOL_SIZE];

    int          error_count = 0;
    bit          steady_flow = 0;
    int          stall_left  = 0;
    longint      cycle_count = 0;

    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long pause; never a gap in steady flow.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void empty_entries();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_key[i]     = '0;
            shadow_stacks[i]  = '0;
            shadow_payload[i] = '0;
            shadow_seq[i]     = '0;
        end
        live_entries = 0;
    endfunction

    function automatic void reset_shadow();
        empty_entries();
        seq_next       = 32'd1;
        rev_count      = '0;
        cur_generation = '0;
        cur_frame      = '0;
        frame_seen     = 1'b0;
    endfunction

    function automatic int find_entry(input logic [63:0] key);
        for (int i = 0; i < live_entries; i++)
            if (shadow_key[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it must produce.
    function automatic okt_out_t apply_table_op(input table_req_t t);
        okt_out_t    r;
        status_t     st;
        int          pos;
        logic [15:0] stk;
        r   = '0;
        st  = ST_DONE;
        case (t.op)
            OP_UPSERT:
            begin
                stk = (t.stacks == '0) ? 16'd1 : t.stacks;
                pos = find_entry(t.key);
                if (t.key == '0)
                    st = ST_KEY_ZERO;
                else if (pos >= 0)
                begin
                    // Overwrite in place; the sequence number stays.
                    shadow_stacks[pos]  = stk;
                    shadow_payload[pos] = t.payload;
                    rev_count++;
                end
                else if (live_entries >= TABLE_DEPTH)
                    st = ST_FULL;
                else
                begin
                    shadow_key[live_entries]     = t.key;
                    shadow_stacks[live_entries]  = stk;
                    shadow_payload[live_entries] = t.payload;
                    shadow_seq[live_entries]     = seq_next;
                    seq_next++;
                    if (seq_next == '0)
                        seq_next = 32'd1;
                    live_entries++;
                    rev_count++;
                end
            end
            OP_REMOVE:
            begin
                pos = find_entry(t.key);
                if (t.key == '0)
                    st = ST_KEY_ZERO;
                else if (pos < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    // Shift later entries down and zero the vacated slot.
                    for (int j = pos; j + 1 < live_entries; j++)
                    begin
                        shadow_key[j]     = shadow_key[j + 1];
                        shadow_stacks[j]  = shadow_stacks[j + 1];
                        shadow_payload[j] = shadow_payload[j + 1];
                        shadow_seq[j]     = shadow_seq[j + 1];
                    end
                    live_entries--;
                    shadow_key[live_entries]     = '0;
                    shadow_stacks[live_entries]  = '0;
                    shadow_payload[live_entries] = '0;
                    shadow_seq[live_entries]     = '0;
                    rev_count++;
                end
            end
            OP_CLEAR:
            begin
                empty_entries();
                rev_count++;
            end
            OP_PUBLISH:
            begin
                if (t.generation == '0)
                    st = ST_IGNORED;
                else
                begin
                    if (cur_generation != t.generation)
                    begin
                        empty_entries();
                        cur_generation = t.generation;
                        rev_count++;
                    end
                    cur_frame  = t.frame;
                    frame_seen = 1'b1;
                end
            end
            OP_BEGIN:
            begin
                empty_entries();
                cur_frame      = '0;
                frame_seen     = 1'b0;
                cur_generation = t.generation;
                rev_count++;
            end
            OP_END:
            begin
                if (t.generation != '0 && cur_generation != t.generation)
                    st = ST_IGNORED;
                else
                begin
                    empty_entries();
                    cur_frame      = '0;
                    frame_seen     = 1'b0;
                    cur_generation = '0;
                    rev_count++;
                end
            end
            OP_READ:
            begin
                if (int'(t.index) < live_entries)
                begin
                    r.entry_key      = shadow_key[t.index];
                    r.entry_stacks   = shadow_stacks[t.index];
                    r.entry_payload  = shadow_payload[t.index];
                    r.entry_sequence = shadow_seq[t.index];
                end
            end
            default:
            begin
                // Unused code: no state change, plain done status.
            end
        endcase
        r.status         = st;
        r.live_count     = 5'(live_entries);
        r.revision_out   = rev_count;
        r.generation_out = cur_generation;
        r.frame_out      = cur_frame;
        r.frame_valid    = frame_seen;
        return r;
    endfunction

    // Fill every field with random bits; callers override what a case needs.
    function automatic table_req_t random_req(input logic [2:0] op);
        table_req_t t;
        t.op         = op;
        t.key        = rand64();
        t.stacks     = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        t.payload    = $urandom;
        t.generation = rand64();
        t.frame      = $urandom;
        t.index      = 4'($urandom_range(0, 15));
        return t;
    endfunction

    // Favor keys that collide so overwrites, removes and a full table happen often.
    function automatic logic [63:0] pick_key(input bit prefer_live);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (prefer_live && live_entries > 0 && r < 55)
            return shadow_key[$urandom_range(0, live_entries - 1)];
        if (r < 85)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return rand64();
    endfunction

    function automatic logic [63:0] pick_generation();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 45)
            return cur_generation;
        if (r < 90)
            return gen_pool[$urandom_range(0, GEN_POOL_SIZE - 1)];
        return rand64();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Drive one request at the falling edge, hold it until the transfer, then predict.
    task automatic send_op(input table_req_t t);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.op         = t.op;
        req_ch.key        = t.key;
        req_ch.stacks     = t.stacks;
        req_ch.payload    = t.payload;
        req_ch.generation = t.generation;
        req_ch.frame      = t.frame;
        req_ch.index      = t.index;
        req_ch.valid      = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pending_results.push_back(apply_table_op(t));
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Zero keys, an absent key, a read of the empty table and the unused op code.
    task automatic test_key_errors();
        table_req_t t;
        t = random_req(OP_READ);
        t.index = 4'd0;
        send_op(t);
        t = random_req(OP_UPSERT);
        t.key = '0;
        send_op(t);
        t = random_req(OP_REMOVE);
        t.key = '0;
        send_op(t);
        t = random_req(OP_REMOVE);
        t.key = key_pool[5];
        send_op(t);
        t = random_req(OP_UNUSED);
        send_op(t);
    endtask

    // Fill all slots, the first two with extreme field values, overflow once, then overwrite.
    task automatic test_fill_and_overflow();
        table_req_t t;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            t = random_req(OP_UPSERT);
            t.key = key_pool[i];
            if (i == 0)
            begin
                t.stacks  = '0;
                t.payload = '0;
            end
            else if (i == 1)
            begin
                t.stacks  = '1;
                t.payload = '1;
            end
            send_op(t);
        end
        t = random_req(OP_UPSERT);
        t.key = key_pool[TABLE_DEPTH];
        send_op(t);
        t = random_req(OP_UPSERT);
        t.key    = key_pool[3];
        t.stacks = '0;
        send_op(t);
    endtask

    // Remove the head (shifts every entry) and the tail, then read around the count.
    task automatic test_compaction();
        table_req_t t;
        t = random_req(OP_REMOVE);
        t.key = key_pool[0];
        send_op(t);
        t = random_req(OP_REMOVE);
        t.key = key_pool[TABLE_DEPTH - 1];
        send_op(t);
        t = random_req(OP_READ);
        t.index = 4'd15;
        send_op(t);
        t = random_req(OP_READ);
        t.index = 4'd13;
        send_op(t);
    endtask

    // Walk the session ops: ignored publish, generation change, same generation,
    // foreign end, begin, anonymous end and a clear of a non-empty table.
    task automatic test_session_ops();
        table_req_t t;
        t = random_req(OP_PUBLISH);
        t.generation = '0;
        send_op(t);
        t = random_req(OP_PUBLISH);
        t.generation = '1;
        t.frame      = '1;
        send_op(t);
        t = random_req(OP_UPSERT);
        t.key = key_pool[20];
        send_op(t);
        t = random_req(OP_PUBLISH);
        t.generation = '1;
        t.frame      = '0;
        send_op(t);
        t = random_req(OP_END);
        t.generation = gen_pool[0];
        send_op(t);
        t = random_req(OP_BEGIN);
        t.generation = gen_pool[1];
        send_op(t);
        t = random_req(OP_END);
        t.generation = '0;
        send_op(t);
        t = random_req(OP_UPSERT);
        t.key = key_pool[21];
        send_op(t);
        t = random_req(OP_CLEAR);
        send_op(t);
    endtask

    // Random requests; fill_bias keeps the table near full with few session changes.
    task automatic run_random_ops(input int count, input bit fill_bias);
        table_req_t t;
        int         r;
        logic [2:0] op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (fill_bias)
                op = (r < 60) ? OP_UPSERT : (r < 72) ? OP_REMOVE : (r < 92) ? OP_READ :
                     (r < 94) ? OP_UNUSED : OP_PUBLISH;
            else
                op = (r < 38) ? OP_UPSERT : (r < 58) ? OP_REMOVE : (r < 74) ? OP_READ :
                     (r < 78) ? OP_CLEAR : (r < 88) ? OP_PUBLISH : (r < 93) ? OP_BEGIN :
                     (r < 98) ? OP_END : OP_UNUSED;
            t = random_req(op);
            t.key = pick_key(op == OP_REMOVE);
            t.generation = (fill_bias && op == OP_PUBLISH) ? cur_generation : pick_generation();
            send_op(t);
        end
    endtask

    task automatic test_random_fill();
        run_random_ops(150, 1'b1);
    endtask

    // Run with no idling on either side.
    task automatic test_steady_stream();
        steady_flow = 1'b1;
        run_random_ops(60, 1'b0);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_mixed();
        run_random_ops(200, 1'b0);
    endtask

    // Result side: drive ready at the falling edge with random stalls.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                stall_left   = pick_gap();
            end
        end
    end

    // Compare every result transfer with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        okt_out_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result transfer with nothing owed, status %h",
                         $time, rsp_ch.status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(rsp_ch.status));
                check_field("entry_key", want.entry_key, rsp_ch.entry_key);
                check_field("entry_stacks", 64'(want.entry_stacks),
                            64'(rsp_ch.entry_stacks));
                check_field("entry_payload", 64'(want.entry_payload),
                            64'(rsp_ch.entry_payload));
                check_field("entry_sequence", 64'(want.entry_sequence),
                            64'(rsp_ch.entry_sequence));
                check_field("live_count", 64'(want.live_count), 64'(rsp_ch.live_count));
                check_field("revision_out", 64'(want.revision_out),
                            64'(rsp_ch.revision_out));
                check_field("generation_out", want.generation_out, rsp_ch.generation_out);
                check_field("frame_out", 64'(want.frame_out), 64'(rsp_ch.frame_out));
                check_field("frame_valid", 64'(want.frame_valid), 64'(rsp_ch.frame_valid));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results still owed",
                     $time, pending_results.size());
            $display("** ordered_keyed_table_engine_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = '0;
        req_ch.key        = '0;
        req_ch.stacks     = '0;
        req_ch.payload    = '0;
        req_ch.generation = '0;
        req_ch.frame      = '0;
        req_ch.index      = '0;
        reset_shadow();

        // Keep the key pool larger than the table so appends can overflow.
        for (int i = 0; i < KEY_POOL_SIZE; i++)
        begin
            key_pool[i] = rand64();
            if (key_pool[i] == '0)
                key_pool[i] = 64'd1 << i;
        end
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        for (int i = 0; i < GEN_POOL_SIZE; i++)
            gen_pool[i] = rand64() | 64'd1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_key_errors();
        test_fill_and_overflow();
        test_compaction();
        test_session_ops();
        // Pause the sender until the block has answered everything.
        hold_until_drained();
        test_random_fill();
        test_steady_stream();
        test_random_mixed();
        hold_until_drained();
        // Leave room for a stray late result.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** ordered_keyed_table_engine_top: PASSED **");
        else
            $display("** ordered_keyed_table_engine_top: FAILED **");
        $finish;
    end

endmodule
